// File: rtl/elrd_pkg.sv
// ============================================================================
// elrd_pkg: shared types and constants of the event log ring
// Request and result beat layouts, request codes and parameter defaults.
// ============================================================================
package elrd_pkg;

	// Parameter defaults
	localparam int DEPTH_DEF        = 256;
	localparam int PAYLOAD_BITS_DEF = 64;
	localparam int MAX_PAGE_DEF     = 64;

	// Fixed field widths
	localparam int SEQ_W     = 32;
	localparam int BODY_W    = 64;
	localparam int OFFSET_W  = 8;
	localparam int LIMIT_W   = 7;
	localparam int COUNT_W   = 9;
	localparam int CAP_W     = 9;

	// Request codes
	localparam logic [1:0] REQ_APPEND  = 2'd0;
	localparam logic [1:0] REQ_RM_ONE  = 2'd1;
	localparam logic [1:0] REQ_RM_UPTO = 2'd2;
	localparam logic [1:0] REQ_READ    = 2'd3;

	// Result status codes
	localparam logic STAT_DONE   = 1'b0;
	localparam logic STAT_REJECT = 1'b1;

	// One request beat
	typedef struct packed {
		logic [1:0]          req_type;
		logic [SEQ_W-1:0]    seq_in;
		logic [BODY_W-1:0]   payload_in;
		logic [OFFSET_W-1:0] read_offset;
		logic [LIMIT_W-1:0]  read_limit;
	} req_t;

	// One result beat
	typedef struct packed {
		logic                status;
		logic                entry_valid;
		logic [SEQ_W-1:0]    seq_out;
		logic [BODY_W-1:0]   payload_out;
		logic [OFFSET_W-1:0] logical_index;
		logic [COUNT_W-1:0]  entry_count;
		logic [SEQ_W-1:0]    dropped_count;
		logic [SEQ_W-1:0]    next_seq;
		logic                last;
	} rsp_t;

endpackage

// File: rtl/elrd_mem.sv
// ============================================================================
// elrd_mem: entry storage of the event log ring
// One write port and one read port; read data is registered and holds
// its value until the next read.
// ============================================================================
module elrd_mem #(
	parameter int DEPTH = elrd_pkg::DEPTH_DEF,
	parameter int WIDTH = elrd_pkg::SEQ_W + elrd_pkg::PAYLOAD_BITS_DEF,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: rtl/elrd_ctrl.sv
// ============================================================================
// elrd_ctrl: request sequencer of the event log ring
// Holds the ring pointers and counters, runs appends, compaction walks for
// removes and page reads against the entry memory, and emits result beats.
// ============================================================================
module elrd_ctrl #(
	parameter int DEPTH        = elrd_pkg::DEPTH_DEF,
	parameter int PAYLOAD_BITS = elrd_pkg::PAYLOAD_BITS_DEF,
	parameter int MAX_PAGE     = elrd_pkg::MAX_PAGE_DEF,
	localparam int PW          = $clog2(DEPTH),
	localparam int CW          = $clog2(DEPTH + 1),
	localparam int EW          = elrd_pkg::SEQ_W + PAYLOAD_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// Request channel
	input  logic                         req_valid,
	output logic                         req_ready,
	input  elrd_pkg::req_t               req,
	// Configuration channel
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [elrd_pkg::CAP_W-1:0]   cfg_data,
	// Result push into the output register
	input  logic                         slot_free,
	output logic                         res_push,
	output elrd_pkg::rsp_t               res,
	// Entry memory
	output logic                         mem_we,
	output logic [PW-1:0]                mem_waddr,
	output logic [EW-1:0]                mem_wdata,
	output logic                         mem_re,
	output logic [PW-1:0]                mem_raddr,
	input  logic [EW-1:0]                mem_rdata
);

	typedef enum logic [5:0] {
		S_IDLE    = 6'b000001,
		S_EXEC    = 6'b000010,
		S_RM      = 6'b000100,
		S_RD_DATA = 6'b001000,
		S_RESULT  = 6'b010000,
		S_SPARE   = 6'b100000
	} state_t;

	state_t                      state_q;
	elrd_pkg::req_t              req_q;
	logic [PW-1:0]               oldest_q;
	logic [CW-1:0]               count_q;
	logic [CW-1:0]               cap_q;
	logic [elrd_pkg::SEQ_W-1:0]  seq_ctr_q;
	logic [elrd_pkg::SEQ_W-1:0]  drop_q;
	logic [PW-1:0]               rp_q;
	logic [PW-1:0]               wp_q;
	logic [CW-1:0]               walk_q;
	logic [CW-1:0]               kept_q;
	logic                        v_s1;
	logic [CW-1:0]               lidx_q;
	logic [elrd_pkg::LIMIT_W-1:0] left_q;
	logic                        status_q;
	logic [elrd_pkg::SEQ_W-1:0]  res_seq_q;

	logic [elrd_pkg::SEQ_W-1:0]  app_seq;
	logic [PW-1:0]               app_idx;
	logic                        app_full;
	logic                        rm_reject;
	logic                        rm_erase;
	logic                        walk_issue;
	logic [elrd_pkg::LIMIT_W-1:0] limit_c;
	logic                        rd_empty;
	logic [31:0]                 rd_avail;
	logic [elrd_pkg::LIMIT_W-1:0] rd_n;
	logic [PW-1:0]               rd_first;
	logic [elrd_pkg::SEQ_W-1:0]  rd_seq;
	logic [CW-1:0]               cap_new;

	// Ring position a + b, reduced once by the capacity (both inputs below it).
	function automatic logic [PW-1:0] ring_add(input logic [PW-1:0] a,
			input logic [CW-1:0] b, input logic [CW-1:0] cap);
		logic [CW:0] s;
		s = (CW+1)'(a) + (CW+1)'(b);
		if (s >= (CW+1)'(cap)) begin
			s = s - (CW+1)'(cap);
		end
		return PW'(s);
	endfunction

	// Next ring position, wrapping at the capacity.
	function automatic logic [PW-1:0] ring_inc(input logic [PW-1:0] a,
			input logic [CW-1:0] cap);
		logic [CW:0] s;
		s = (CW+1)'(a) + (CW+1)'(1);
		if (s == (CW+1)'(cap)) begin
			s = '0;
		end
		return PW'(s);
	endfunction

	// Append: sequence to store and slot to fill.
	always_comb begin
		app_seq  = (req_q.seq_in == '0) ? seq_ctr_q : req_q.seq_in;
		app_full = (count_q >= cap_q);
		app_idx  = app_full ? oldest_q : ring_add(oldest_q, count_q, cap_q);
	end

	// Remove: rejection and per-entry erase decision during the walk.
	assign rm_reject  = (req_q.seq_in == '0) || (req_q.seq_in >= seq_ctr_q);
	assign rd_seq     = mem_rdata[EW-1 -: elrd_pkg::SEQ_W];
	assign rm_erase   = (req_q.req_type == elrd_pkg::REQ_RM_UPTO) ?
		(rd_seq <= req_q.seq_in) : (rd_seq == req_q.seq_in);
	assign walk_issue = (walk_q != count_q);

	// Page read: clamp the limit and size the page.
	always_comb begin
		limit_c  = (32'(req_q.read_limit) > 32'(MAX_PAGE)) ?
			elrd_pkg::LIMIT_W'(MAX_PAGE) : req_q.read_limit;
		rd_empty = (limit_c == '0) || (32'(req_q.read_offset) >= 32'(count_q));
		rd_avail = 32'(count_q) - 32'(req_q.read_offset);
		rd_n     = (rd_avail > 32'(limit_c)) ? limit_c : elrd_pkg::LIMIT_W'(rd_avail);
		rd_first = ring_add(oldest_q, CW'(req_q.read_offset), cap_q);
	end

	// Configuration value clamped to 1..DEPTH.
	always_comb begin
		if (cfg_data == '0) begin
			cap_new = CW'(1);
		end else if (32'(cfg_data) > 32'(DEPTH)) begin
			cap_new = CW'(DEPTH);
		end else begin
			cap_new = CW'(cfg_data);
		end
	end

	assign req_ready = (state_q == S_IDLE);
	assign cfg_ready = (state_q == S_IDLE);

	// Memory controls and result beat.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = wp_q;
		mem_wdata = mem_rdata;
		mem_re    = 1'b0;
		mem_raddr = rp_q;
		res_push  = 1'b0;

		res.status        = status_q;
		res.entry_valid   = 1'b0;
		res.seq_out       = res_seq_q;
		res.payload_out   = '0;
		res.logical_index = '0;
		res.entry_count   = elrd_pkg::COUNT_W'(count_q);
		res.dropped_count = drop_q;
		res.next_seq      = seq_ctr_q;
		res.last          = 1'b1;

		case (state_q)
			S_EXEC: begin
				if (req_q.req_type == elrd_pkg::REQ_APPEND) begin
					mem_we    = 1'b1;
					mem_waddr = app_idx;
					mem_wdata = {app_seq, req_q.payload_in[PAYLOAD_BITS-1:0]};
				end else if (req_q.req_type == elrd_pkg::REQ_READ && !rd_empty) begin
					mem_re    = 1'b1;
					mem_raddr = rd_first;
				end
			end
			S_RM: begin
				mem_re = walk_issue;
				mem_we = v_s1 && !rm_erase;
			end
			S_RD_DATA: begin
				res_push          = slot_free;
				mem_re            = slot_free && (left_q != elrd_pkg::LIMIT_W'(1));
				res.status        = elrd_pkg::STAT_DONE;
				res.entry_valid   = 1'b1;
				res.seq_out       = rd_seq;
				res.payload_out   = elrd_pkg::BODY_W'(mem_rdata[PAYLOAD_BITS-1:0]);
				res.logical_index = elrd_pkg::OFFSET_W'(lidx_q);
				res.last          = (left_q == elrd_pkg::LIMIT_W'(1));
			end
			S_RESULT: begin
				res_push = slot_free;
			end
			default: begin
			end
		endcase
	end

	// Request latch.
	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_q <= req;
		end
	end

	// Sequencer and ring state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			oldest_q  <= '0;
			count_q   <= '0;
			cap_q     <= CW'(DEPTH);
			seq_ctr_q <= elrd_pkg::SEQ_W'(1);
			drop_q    <= '0;
			rp_q      <= '0;
			wp_q      <= '0;
			walk_q    <= '0;
			kept_q    <= '0;
			v_s1      <= 1'b0;
			lidx_q    <= '0;
			left_q    <= '0;
			status_q  <= elrd_pkg::STAT_DONE;
			res_seq_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cfg_valid && count_q == '0) begin
						cap_q    <= cap_new;
						oldest_q <= '0;
					end
					if (req_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					status_q  <= elrd_pkg::STAT_DONE;
					res_seq_q <= '0;
					case (req_q.req_type)
						elrd_pkg::REQ_APPEND: begin
							res_seq_q <= app_seq;
							if (req_q.seq_in == '0) begin
								seq_ctr_q <= seq_ctr_q + elrd_pkg::SEQ_W'(1);
							end else if (req_q.seq_in >= seq_ctr_q) begin
								seq_ctr_q <= req_q.seq_in + elrd_pkg::SEQ_W'(1);
							end
							if (app_full) begin
								oldest_q <= ring_inc(oldest_q, cap_q);
								drop_q   <= drop_q + elrd_pkg::SEQ_W'(1);
							end else begin
								count_q <= count_q + CW'(1);
							end
							state_q <= S_RESULT;
						end
						elrd_pkg::REQ_RM_ONE, elrd_pkg::REQ_RM_UPTO: begin
							if (rm_reject) begin
								status_q <= elrd_pkg::STAT_REJECT;
								state_q  <= S_RESULT;
							end else begin
								rp_q    <= oldest_q;
								wp_q    <= oldest_q;
								walk_q  <= '0;
								kept_q  <= '0;
								v_s1    <= 1'b0;
								state_q <= S_RM;
							end
						end
						elrd_pkg::REQ_READ: begin
							if (rd_empty) begin
								state_q <= S_RESULT;
							end else begin
								rp_q    <= ring_inc(rd_first, cap_q);
								lidx_q  <= CW'(req_q.read_offset);
								left_q  <= rd_n;
								state_q <= S_RD_DATA;
							end
						end
						default: begin
							state_q <= S_RESULT;
						end
					endcase
				end
				S_RM: begin
					// Read side runs at least one entry ahead of the write side.
					if (walk_issue) begin
						rp_q   <= ring_inc(rp_q, cap_q);
						walk_q <= walk_q + CW'(1);
					end
					v_s1 <= walk_issue;
					// Survivors pack down toward the oldest slot.
					if (v_s1 && !rm_erase) begin
						wp_q   <= ring_inc(wp_q, cap_q);
						kept_q <= kept_q + CW'(1);
					end
					if (!walk_issue && !v_s1) begin
						count_q <= kept_q;
						state_q <= S_RESULT;
					end
				end
				S_RD_DATA: begin
					if (slot_free) begin
						if (left_q == elrd_pkg::LIMIT_W'(1)) begin
							state_q <= S_IDLE;
						end else begin
							rp_q   <= ring_inc(rp_q, cap_q);
							lidx_q <= lidx_q + CW'(1);
							left_q <= left_q - elrd_pkg::LIMIT_W'(1);
						end
					end
				end
				S_RESULT: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// File: rtl/event_log_ring_with_delete_core.sv
// ============================================================================
// event_log_ring_with_delete_core: sequence-numbered event log in a ring
// Top level: entry memory, request sequencer and the result output register.
// ============================================================================
// Usage:
// A request beat on req (valid/ready) is an append, a remove of one sequence,
// a remove of all sequences up to a value, or a page read. Every request
// yields result beats on rsp (valid/ready); the final beat of a request has
// last set. An append or a remove yields one beat, a page read one beat per
// entry returned (up to MAX_PAGE), or a single empty beat.
// cfg (valid/ready) writes the ring capacity; it is taken only between
// requests and ignored while the log holds entries.
// Timing: one request at a time. An append, a rejected remove or an empty
// page passes through the execute and result states and the output register
// before its beat is valid, and the next request is taken once the result
// state has handed its beat on. A remove walks every stored entry through
// the memory's single read port and write port before its result state.
// A page read issues its first registered memory read in the execute state,
// then delivers one entry per cycle while the receiver takes them, and goes
// back to idle with its last entry.
// When the receiver holds rsp_ready low, the result register holds its beat,
// a page read pauses and nothing is lost. Reset empties the log, sets the
// next sequence to one, clears the drop count and selects the full capacity.
module event_log_ring_with_delete_core #(
	parameter int DEPTH        = elrd_pkg::DEPTH_DEF,
	parameter int PAYLOAD_BITS = elrd_pkg::PAYLOAD_BITS_DEF,
	parameter int MAX_PAGE     = elrd_pkg::MAX_PAGE_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_ready,
	input  elrd_pkg::req_t             req,
	output logic                       rsp_valid,
	input  logic                       rsp_ready,
	output elrd_pkg::rsp_t             rsp,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [elrd_pkg::CAP_W-1:0] cfg_data
);

	localparam int PW = $clog2(DEPTH);
	localparam int EW = elrd_pkg::SEQ_W + PAYLOAD_BITS;

	logic           mem_we;
	logic [PW-1:0]  mem_waddr;
	logic [EW-1:0]  mem_wdata;
	logic           mem_re;
	logic [PW-1:0]  mem_raddr;
	logic [EW-1:0]  mem_rdata;
	logic           slot_free;
	logic           res_push;
	elrd_pkg::rsp_t res;
	logic           rsp_valid_q;
	elrd_pkg::rsp_t rsp_q;

	elrd_mem #(
		.DEPTH (DEPTH),
		.WIDTH (EW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	elrd_ctrl #(
		.DEPTH        (DEPTH),
		.PAYLOAD_BITS (PAYLOAD_BITS),
		.MAX_PAGE     (MAX_PAGE)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.slot_free (slot_free),
		.res_push  (res_push),
		.res       (res),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	// The output register can take a new beat when empty or being drained.
	assign slot_free = !rsp_valid_q || rsp_ready;

	// Result output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (slot_free) begin
			rsp_valid_q <= res_push;
		end
	end

	always_ff @(posedge clk) begin
		if (slot_free && res_push) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// File: bench/tb_event_log_ring_with_delete_core.sv
// ============================================================================
// tb_event_log_ring_with_delete_core: self-checking bench for the event log
// Drives appends, removes and page reads with random pacing and receiver
// stalls. It rewrites the ring capacity between phases, including values out
// of range and a write while entries are still held. A shadow of the log
// predicts every result beat, and each beat is compared field by field.
// ============================================================================
module tb_event_log_ring_with_delete_core;
	import elrd_pkg::*;

	localparam int REPORT_MAX   = 10;
	localparam int SETTLE       = 16;
	localparam int PHASE_ITEMS  = 37;
	localparam int TIMEOUT_TIME = 40_000_000;

	// Shadow of the log: ring contents, counters and the beats still owed.
	class log_shadow;
		bit [SEQ_W-1:0]  slot_seq [DEPTH_DEF];
		bit [BODY_W-1:0] slot_body [DEPTH_DEF];
		int unsigned     head;
		int unsigned     fill;
		int unsigned     slots;
		bit [SEQ_W-1:0]  next_number;
		bit [SEQ_W-1:0]  drop_total;
		rsp_t            owed_beats [$];
		int unsigned     mismatches;
		int unsigned     beats_checked;

		function new();
			head = 0;
			fill = 0;
			slots = DEPTH_DEF;
			next_number = 1;
			drop_total = 0;
			mismatches = 0;
			beats_checked = 0;
		endfunction

		// Queue one expected beat; the counters reflect the state after the request.
		function void owe_beat(logic status, logic valid, logic [SEQ_W-1:0] seq,
			logic [BODY_W-1:0] body, int unsigned lidx, logic last);
			rsp_t b;
			b.status        = status;
			b.entry_valid   = valid;
			b.seq_out       = seq;
			b.payload_out   = body;
			b.logical_index = lidx[OFFSET_W-1:0];
			b.entry_count   = fill[COUNT_W-1:0];
			b.dropped_count = drop_total;
			b.next_seq      = next_number;
			b.last          = last;
			owed_beats.push_back(b);
		endfunction

		// A capacity write only lands on an empty log and restarts the ring at slot 0.
		function void note_capacity(logic [CAP_W-1:0] v);
			int unsigned c;
			if (fill != 0)
				return;
			c = v;
			if (c < 1)
				c = 1;
			if (c > DEPTH_DEF)
				c = DEPTH_DEF;
			slots = c;
			head = 0;
		endfunction

		// Advance the shadow by one accepted request and queue its result beats.
		function void apply_request(req_t r);
			logic [SEQ_W-1:0] s;
			int unsigned at;
			int unsigned lim;
			int unsigned n;
			int unsigned kept;
			int unsigned to_pos;
			bit erase;
			s = r.seq_in;
			case (r.req_type)
			REQ_APPEND: begin
				if (s == 0) begin
					s = next_number;
					next_number = next_number + 1;
				end else if (s >= next_number) begin
					next_number = s + 1;
				end
				if (fill < slots) begin
					at = (head + fill) % slots;
					fill++;
				end else begin
					// Full ring: the oldest entry gives way.
					at = head;
					head = (head + 1) % slots;
					drop_total = drop_total + 1;
				end
				slot_seq[at] = s;
				slot_body[at] = r.payload_in;
				owe_beat(STAT_DONE, 1'b0, s, '0, 0, 1'b1);
			end
			REQ_RM_ONE, REQ_RM_UPTO: begin
				if (s == 0 || s >= next_number) begin
					owe_beat(STAT_REJECT, 1'b0, '0, '0, 0, 1'b1);
				end else begin
					// Survivors are packed in order starting at the oldest slot.
					kept = 0;
					for (int unsigned i = 0; i < fill; i++) begin
						at = (head + i) % slots;
						erase = (r.req_type == REQ_RM_UPTO) ? (slot_seq[at] <= s)
							: (slot_seq[at] == s);
						if (!erase) begin
							to_pos = (head + kept) % slots;
							kept++;
							slot_seq[to_pos] = slot_seq[at];
							slot_body[to_pos] = slot_body[at];
						end
					end
					fill = kept;
					owe_beat(STAT_DONE, 1'b0, '0, '0, 0, 1'b1);
				end
			end
			default: begin
				lim = (r.read_limit > MAX_PAGE_DEF) ? MAX_PAGE_DEF : r.read_limit;
				if (lim == 0 || r.read_offset >= fill) begin
					owe_beat(STAT_DONE, 1'b0, '0, '0, 0, 1'b1);
				end else begin
					n = fill - r.read_offset;
					if (n > lim)
						n = lim;
					for (int unsigned i = 0; i < n; i++) begin
						at = (head + r.read_offset + i) % slots;
						owe_beat(STAT_DONE, 1'b1, slot_seq[at], slot_body[at],
							r.read_offset + i, (i + 1 == n));
					end
				end
			end
			endcase
		endfunction

		function string beat_text(rsp_t b);
			return $sformatf({"st=%0d ev=%0d seq=%h body=%h idx=%0d",
				" cnt=%0d drop=%0d next=%h last=%0d"},
				b.status, b.entry_valid, b.seq_out, b.payload_out, b.logical_index,
				b.entry_count, b.dropped_count, b.next_seq, b.last);
		endfunction

		function void report(string what, rsp_t want, rsp_t got);
			mismatches++;
			if (mismatches <= REPORT_MAX) begin
				$display("[%0t] MISMATCH %s", $realtime, what);
				$display("  expected %s", beat_text(want));
				$display("  actual   %s", beat_text(got));
			end
		endfunction

		// Compare one accepted result beat against the oldest owed beat.
		function void match_beat(rsp_t got);
			rsp_t want;
			string bad;
			beats_checked++;
			if (owed_beats.size() == 0) begin
				report("result beat with nothing owed", '0, got);
				return;
			end
			want = owed_beats.pop_front();
			bad = "";
			if (got.status !== want.status)
				bad = {bad, " status"};
			if (got.entry_valid !== want.entry_valid)
				bad = {bad, " entry_valid"};
			if (got.seq_out !== want.seq_out)
				bad = {bad, " seq_out"};
			if (got.payload_out !== want.payload_out)
				bad = {bad, " payload_out"};
			if (got.logical_index !== want.logical_index)
				bad = {bad, " logical_index"};
			if (got.entry_count !== want.entry_count)
				bad = {bad, " entry_count"};
			if (got.dropped_count !== want.dropped_count)
				bad = {bad, " dropped_count"};
			if (got.next_seq !== want.next_seq)
				bad = {bad, " next_seq"};
			if (got.last !== want.last)
				bad = {bad, " last"};
			if (bad != "")
				report({"field", bad}, want, got);
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               req_valid = 1'b0;
	logic               req_ready;
	req_t               req = '0;
	logic               rsp_valid;
	logic               rsp_ready = 1'b0;
	rsp_t               rsp;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [CAP_W-1:0]   cfg_data = '0;

	log_shadow          sb = new();
	int unsigned        burst_left = 0;
	bit                 steady = 1'b0;
	int unsigned        items_sent = 0;
	int unsigned        cfg_writes = 0;
	logic [15:0]        stall_pat = 16'hFFFF;
	int unsigned        stall_age = 0;

	event_log_ring_with_delete_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #6 clk = ~clk;

	// Receiver: a rotating ready pattern, replaced by a new random one when its age runs out.
	always @(posedge clk) begin
		if (stall_age == 0) begin
			case ($urandom_range(3, 0))
			0: stall_pat <= 16'hFFFF;
			1: stall_pat <= 16'($urandom) | 16'h0001;
			2: stall_pat <= 16'h0001 << $urandom_range(15, 0);
			default: stall_pat <= 16'($urandom) | 16'($urandom);
			endcase
			stall_age <= $urandom_range(80, 20);
		end else begin
			stall_pat <= {stall_pat[0], stall_pat[15:1]};
			stall_age <= stall_age - 1;
		end
		rsp_ready <= stall_pat[0];
	end

	// Check every result beat taken by the receiver.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready)
			sb.match_beat(rsp);
	end

	// Hard stop in case the block hangs.
	initial begin
		#(TIMEOUT_TIME);
		$display("timeout with %0d result beats still owed", sb.owed_beats.size());
		$display("simulation failed");
		$finish;
	end

	function automatic req_t mk(logic [1:0] kind, logic [SEQ_W-1:0] seq,
		logic [BODY_W-1:0] body, logic [OFFSET_W-1:0] offset, logic [LIMIT_W-1:0] limit);
		req_t r;
		r.req_type    = kind;
		r.seq_in      = seq;
		r.payload_in  = body;
		r.read_offset = offset;
		r.read_limit  = limit;
		return r;
	endfunction

	// Mostly well-formed traffic: appends near the counter, removes of stored
	// numbers, reads around the fill level, plus rejects and odd limits.
	function automatic req_t rand_request();
		req_t r;
		int unsigned pick;
		r = mk(REQ_APPEND, $urandom, {$urandom, $urandom}, $urandom, $urandom);
		pick = $urandom_range(99, 0);
		if (pick < 45) begin
			pick = $urandom_range(99, 0);
			if (pick < 60)
				r.seq_in = '0;
			else if (pick < 85 || sb.next_number < 2)
				r.seq_in = sb.next_number + $urandom_range(5, 0);
			else
				r.seq_in = $urandom_range(sb.next_number - 1, 1);
		end else if (pick < 75) begin
			r.req_type = REQ_READ;
			if ($urandom_range(3, 0) != 0 && sb.fill + 2 <= 255)
				r.read_offset = $urandom_range(sb.fill + 2, 0);
			if ($urandom_range(3, 0) != 0)
				r.read_limit = $urandom_range(8, 1);
		end else begin
			r.req_type = (pick < 90) ? REQ_RM_ONE : REQ_RM_UPTO;
			pick = $urandom_range(99, 0);
			if (pick < 70 && sb.fill != 0)
				r.seq_in = sb.slot_seq[(sb.head + $urandom_range(sb.fill - 1, 0)) % sb.slots];
			else if (pick < 80)
				r.seq_in = '0;
			else if (pick < 90 || sb.next_number < 2)
				r.seq_in = $urandom;
			else
				r.seq_in = $urandom_range(sb.next_number - 1, 1);
		end
		return r;
	endfunction

	// Offer one request beat and hold it until taken; valid stays high after.
	task automatic send_req(input req_t r);
		req <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		sb.apply_request(r);
		items_sent++;
	endtask

	// Sender pacing: bursts of random length separated by random gaps.
	task automatic put(input req_t r);
		if (!steady) begin
			if (burst_left == 0) begin
				req_valid <= 1'b0;
				repeat ($urandom_range(9, 1)) @(posedge clk);
				burst_left = $urandom_range(12, 1);
			end
			burst_left--;
		end
		send_req(r);
	endtask

	// Drop valid and wait until every owed beat has arrived.
	task automatic drain();
		req_valid <= 1'b0;
		while (sb.owed_beats.size() != 0) @(posedge clk);
	endtask

	// Capacity write on an idle block; the caller has already dropped valid.
	task automatic write_capacity(input logic [CAP_W-1:0] v);
		while (sb.owed_beats.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_data <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		sb.note_capacity(v);
		cfg_valid <= 1'b0;
		cfg_writes++;
	endtask

	// One random phase: empty the log, set the capacity, then random traffic
	// with one full drain at a random point in it.
	task automatic run_phase(input logic [CAP_W-1:0] cap);
		int unsigned hold_at;
		if (sb.fill != 0) begin
			send_req(mk(REQ_RM_UPTO, sb.next_number - 1, '0, '0, '0));
			drain();
		end
		write_capacity(cap);
		steady = ($urandom_range(3, 0) == 0);
		hold_at = $urandom_range(PHASE_ITEMS - 1, 0);
		for (int unsigned k = 0; k < PHASE_ITEMS; k++) begin
			if (k == hold_at) begin
				drain();
				send_req(rand_request());
			end else begin
				put(rand_request());
			end
		end
		drain();
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty log: empty page, zero remove, remove of a number not yet issued.
		put(mk(REQ_READ, '0, '0, 8'd0, 7'd5));
		put(mk(REQ_RM_ONE, '0, '0, '0, '0));
		put(mk(REQ_RM_UPTO, 32'd1, '0, '0, '0));
		// Unnumbered and numbered appends, one of them below the counter.
		put(mk(REQ_APPEND, '0, '0, '0, '0));
		put(mk(REQ_APPEND, '0, '1, 8'hFF, 7'h7F));
		put(mk(REQ_APPEND, 32'd100, {$urandom, $urandom}, '0, '0));
		put(mk(REQ_APPEND, 32'd50, {$urandom, $urandom}, '0, '0));
		// Page reads: oversize limit, zero limit, offset at and past the count.
		put(mk(REQ_READ, '0, '0, 8'd0, 7'h7F));
		put(mk(REQ_READ, '0, '0, 8'd0, 7'd0));
		put(mk(REQ_READ, '0, '0, 8'd4, 7'd64));
		put(mk(REQ_READ, '1, '1, 8'hFF, 7'd1));
		put(mk(REQ_READ, '0, '0, 8'd1, 7'd2));
		// Removes: present, absent, unissued with the top bit set, and a range.
		put(mk(REQ_RM_ONE, 32'd50, '0, '0, '0));
		put(mk(REQ_RM_ONE, 32'd7, '0, '0, '0));
		put(mk(REQ_RM_UPTO, '1, '0, '0, '0));
		put(mk(REQ_RM_UPTO, 32'd2, '0, '0, '0));
		put(mk(REQ_READ, '0, '0, 8'd0, 7'd64));
		drain();
		// One entry is still held, so this capacity write must be ignored.
		write_capacity(9'd3);
		put(mk(REQ_RM_UPTO, 32'd100, '0, '0, '0));
		drain();
		// Zero capacity acts as a single slot; once it is filled, each append overwrites it.
		write_capacity(9'd0);
		put(mk(REQ_APPEND, '1, {$urandom, $urandom}, '0, '0));
		put(mk(REQ_APPEND, '0, {$urandom, $urandom}, '0, '0));
		put(mk(REQ_READ, '0, '0, 8'd0, 7'd1));
		put(mk(REQ_APPEND, 32'd5, {$urandom, $urandom}, '0, '0));
		put(mk(REQ_RM_UPTO, 32'd5, '0, '0, '0));
		drain();
		// Oversize capacity acts as the full ring.
		write_capacity(9'h1FF);

		run_phase(9'd256);
		run_phase(9'd2);
		run_phase(9'd1);
		run_phase(9'd17);
		run_phase(9'($urandom_range(40, 3)));
		run_phase(9'd64);

		drain();
		repeat (SETTLE) @(posedge clk);
		$display("covered %0d requests and %0d result beats over %0d capacity writes",
			items_sent, sb.beats_checked, cfg_writes);
		$display("log ends with %0d entries, %0d dropped, next number %0d, %0d mismatches",
			sb.fill, sb.drop_total, sb.next_number, sb.mismatches);
		if (sb.mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
